### sv/tcwe_pkg.sv
package tcwe_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int DEFAULT_ROUNDS = 32;
   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E37_79B9;

   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD0_INDEX = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD1_INDEX = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD2_INDEX = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD3_INDEX = 8'd3;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] k0;
      logic [WORD_WIDTH-1:0] k1;
      logic [WORD_WIDTH-1:0] k2;
      logic [WORD_WIDTH-1:0] k3;
   } key_type;

   // One block in flight through the row of round cells.
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [WORD_WIDTH-1:0] v0;
      logic [WORD_WIDTH-1:0] v1;
   } stage_type;

endpackage

### sv/tcwe_req_if.sv
interface tcwe_req_if;
   logic                             valid;
   logic                             ready;
   logic [tcwe_pkg::WORD_WIDTH-1:0]  plain_word;
   logic                             first_of_message;
   logic                             last_of_message;

   modport source (output valid, output plain_word, output first_of_message,
                   output last_of_message, input ready);
   modport sink (input valid, input plain_word, input first_of_message,
                 input last_of_message, output ready);
endinterface

### sv/tcwe_rsp_if.sv
interface tcwe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tcwe_pkg::WORD_WIDTH-1:0]  cipher_word;
   logic                             is_chain_word;
   logic                             end_of_run;

   modport source (output valid, output cipher_word, output is_chain_word,
                   output end_of_run, input ready);
   modport sink (input valid, input cipher_word, input is_chain_word,
                 input end_of_run, output ready);
endinterface

### sv/tcwe_csr_if.sv
interface tcwe_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tcwe_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [tcwe_pkg::WORD_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### sv/tcwe_cell.sv
module tcwe_cell #(
   parameter logic [tcwe_pkg::WORD_WIDTH-1:0] ROUND_SUM = tcwe_pkg::TEA_DELTA
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  tcwe_pkg::key_type    key,
   input  tcwe_pkg::stage_type  stage_in,
   output tcwe_pkg::stage_type  stage_out
);

   logic [tcwe_pkg::WORD_WIDTH-1:0] v0_in;
   logic [tcwe_pkg::WORD_WIDTH-1:0] v1_in;
   logic [tcwe_pkg::WORD_WIDTH-1:0] v0_ff;
   logic [tcwe_pkg::WORD_WIDTH-1:0] v1_ff;
   logic                            valid_ff;
   logic                            last_ff;

   // One TEA cycle: the new low half feeds the high half update.
   always_comb begin
      v0_in = stage_in.v0 + (((stage_in.v1 << 4) + key.k0) ^ (stage_in.v1 + ROUND_SUM)
                             ^ ((stage_in.v1 >> 5) + key.k1));
      v1_in = stage_in.v1 + (((v0_in << 4) + key.k2) ^ (v0_in + ROUND_SUM)
                             ^ ((v0_in >> 5) + key.k3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last_ff <= stage_in.last;
         v0_ff   <= v0_in;
         v1_ff   <= v1_in;
      end
   end

   assign stage_out = '{valid: valid_ff, last: last_ff, v0: v0_ff, v1: v1_ff};

endmodule

### sv/tea_chained_word_encryptor.sv
// Enciphers one 32-bit word per request with ROUNDS TEA iterations, using the
// word as the low half and the running chain word (zero for a word that
// opens a message) as the high half; the enciphered low half comes back as
// the response, and after a word marked last the chain word follows as a
// second response. Each TEA cycle is one cell of a row of ROUNDS cells. A
// word that continues a message needs the chain word left by the word
// before it, so it is taken only once the row is empty. A word that opens
// a message does not depend on the chain word and enters the row directly
// behind anything in flight whenever the row advances. The key registers
// are to be written through the csr port only while the block is idle; the
// block itself does not enforce this. Indexes beyond the four key words
// are ignored.
module tea_chained_word_encryptor #(
   parameter int ROUNDS = tcwe_pkg::DEFAULT_ROUNDS
) (
   input  logic       clock,
   input  logic       reset,
   tcwe_req_if.sink   req_if,
   tcwe_rsp_if.source rsp_if,
   tcwe_csr_if.sink   csr_if
);

   localparam int COUNT_WIDTH = $clog2(ROUNDS + 1);

   tcwe_pkg::key_type               key_ff;
   tcwe_pkg::stage_type             stage [ROUNDS+1];
   logic [tcwe_pkg::WORD_WIDTH-1:0] chain_ff;
   logic [COUNT_WIDTH-1:0]          inflight_ff;
   logic [COUNT_WIDTH-1:0]          inflight_in;
   logic                            rsp_valid_ff;
   logic [tcwe_pkg::WORD_WIDTH-1:0] rsp_word_ff;
   logic                            rsp_chain_ff;
   logic                            rsp_end_ff;
   logic                            chain_pend_ff;
   logic                            exit_free;
   logic                            advance;
   logic                            accept;
   logic                            retire;

   // Key registers.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            tcwe_pkg::KEY_WORD0_INDEX: key_ff.k0 <= csr_if.data;
            tcwe_pkg::KEY_WORD1_INDEX: key_ff.k1 <= csr_if.data;
            tcwe_pkg::KEY_WORD2_INDEX: key_ff.k2 <= csr_if.data;
            tcwe_pkg::KEY_WORD3_INDEX: key_ff.k3 <= csr_if.data;
            default: ;
         endcase
      end
   end

   // The whole row moves together unless a full last cell cannot retire.
   assign exit_free = !rsp_valid_ff || (rsp_if.ready && !chain_pend_ff);
   assign advance   = !stage[ROUNDS].valid || exit_free;
   assign req_if.ready = advance
                         && ((inflight_ff == '0) || req_if.first_of_message);
   assign accept    = req_if.valid && req_if.ready;
   assign retire    = advance && stage[ROUNDS].valid;

   assign stage[0] = '{valid: accept,
                       last:  req_if.last_of_message,
                       v0:    req_if.plain_word,
                       v1:    req_if.first_of_message ? '0 : chain_ff};

   for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
      localparam logic [2*tcwe_pkg::WORD_WIDTH-1:0] SUM_FULL =
         64'(tcwe_pkg::TEA_DELTA) * 64'(g + 1);
      tcwe_cell #(
         .ROUND_SUM (SUM_FULL[tcwe_pkg::WORD_WIDTH-1:0])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .key       (key_ff),
         .stage_in  (stage[g]),
         .stage_out (stage[g+1])
      );
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (accept && !retire) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (retire && !accept) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff   <= '0;
         chain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         chain_pend_ff <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         if (retire) begin
            chain_ff      <= stage[ROUNDS].v1;
            rsp_valid_ff  <= 1'b1;
            chain_pend_ff <= stage[ROUNDS].last;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff  <= chain_pend_ff;
            chain_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_word_ff  <= stage[ROUNDS].v0;
         rsp_chain_ff <= 1'b0;
         rsp_end_ff   <= !stage[ROUNDS].last;
      end else if (rsp_valid_ff && rsp_if.ready && chain_pend_ff) begin
         rsp_word_ff  <= chain_ff;
         rsp_chain_ff <= 1'b1;
         rsp_end_ff   <= 1'b1;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cipher_word   = rsp_word_ff;
   assign rsp_if.is_chain_word = rsp_chain_ff;
   assign rsp_if.end_of_run    = rsp_end_ff;

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= COUNT_WIDTH'(ROUNDS))
      else $error("more words in the row than cells");

   a_pend_needs_valid: assert property (@(posedge clock) disable iff (reset)
      chain_pend_ff |-> rsp_valid_ff)
      else $error("chain word pending without a response held");

   a_chain_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_if.ready && chain_pend_ff) |=> (rsp_valid_ff && rsp_chain_ff))
      else $error("chain word did not follow the last cipher word");

   a_continue_alone: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_if.first_of_message) |-> (inflight_ff == '0))
      else $error("continuing word entered behind words in flight");

endmodule

### tb/testbench.sv
module testbench;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_CYCLES = 300;
   localparam int BURST_WORDS = 48;
   localparam int WORDS_PER_PHASE = 95;
   localparam int KEY_PHASES = 5;
   localparam int MAX_REPORTS = 10;
   localparam int TOP_INDEX = (1 << tcwe_pkg::CSR_INDEX_WIDTH) - 1;
   localparam logic [tcwe_pkg::CSR_INDEX_WIDTH-1:0] SPARE_INDEX =
      tcwe_pkg::KEY_WORD3_INDEX + 8'd1;
   localparam logic [tcwe_pkg::CSR_INDEX_WIDTH-1:0] LAST_INDEX =
      tcwe_pkg::CSR_INDEX_WIDTH'(TOP_INDEX);

   typedef struct packed {
      logic [tcwe_pkg::WORD_WIDTH-1:0] plain_word;
      logic                            first_of_message;
      logic                            last_of_message;
   } plain_row_type;

   typedef struct packed {
      logic [tcwe_pkg::WORD_WIDTH-1:0] cipher_word;
      logic                            is_chain_word;
      logic                            end_of_run;
   } cipher_result_type;

   logic clock = 1'b0;
   logic reset;

   tcwe_req_if req_bus();
   tcwe_rsp_if rsp_bus();
   tcwe_csr_if csr_bus();

   tea_chained_word_encryptor dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   tcwe_pkg::key_type               key_shadow;
   logic [tcwe_pkg::WORD_WIDTH-1:0] chain_shadow;
   cipher_result_type               pending_cipher [$];
   int                              error_count = 0;
   int                              cycle_count = 0;
   bit                              quiet = 1'b0;
   bit                              hold_request = 1'b0;

   // Message openings, closings, continuation straight out of reset and
   // continuation across a finished message, with extreme words.
   plain_row_type directed_words [14] = '{
      '{32'h0000_0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1},
      '{32'h0000_0001, 1'b1, 1'b1},
      '{32'hFFFF_FFFF, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b1, 1'b1},
      '{32'h1234_5678, 1'b1, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b1},
      '{32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1},
      '{32'h0000_0000, 1'b0, 1'b0},
      '{32'hAAAA_5555, 1'b0, 1'b1}
   };

   function automatic void tea_rounds(inout logic [tcwe_pkg::WORD_WIDTH-1:0] lo,
                                      inout logic [tcwe_pkg::WORD_WIDTH-1:0] hi);
      logic [tcwe_pkg::WORD_WIDTH-1:0] total;
      int                              r;
      total = '0;
      for (r = 0; r < tcwe_pkg::DEFAULT_ROUNDS; r++) begin
         total += tcwe_pkg::TEA_DELTA;
         lo += ((hi << 4) + key_shadow.k0) ^ (hi + total) ^ ((hi >> 5) + key_shadow.k1);
         hi += ((lo << 4) + key_shadow.k2) ^ (lo + total) ^ ((lo >> 5) + key_shadow.k3);
      end
   endfunction

   function automatic void queue_cipher(input logic [tcwe_pkg::WORD_WIDTH-1:0] word,
                                        input logic first, input logic last);
      logic [tcwe_pkg::WORD_WIDTH-1:0] lo;
      logic [tcwe_pkg::WORD_WIDTH-1:0] hi;
      lo = word;
      if (first) begin
         chain_shadow = '0;
      end
      hi = chain_shadow;
      tea_rounds(lo, hi);
      chain_shadow = hi;
      pending_cipher.push_back(cipher_result_type'{lo, 1'b0, !last});
      if (last) begin
         pending_cipher.push_back(cipher_result_type'{hi, 1'b1, 1'b1});
      end
   endfunction

   function automatic void apply_key_write(
      input logic [tcwe_pkg::CSR_INDEX_WIDTH-1:0] index,
      input logic [tcwe_pkg::WORD_WIDTH-1:0]      data);
      case (index)
         tcwe_pkg::KEY_WORD0_INDEX: key_shadow.k0 = data;
         tcwe_pkg::KEY_WORD1_INDEX: key_shadow.k1 = data;
         tcwe_pkg::KEY_WORD2_INDEX: key_shadow.k2 = data;
         tcwe_pkg::KEY_WORD3_INDEX: key_shadow.k3 = data;
         default: ;
      endcase
   endfunction

   // Entered right after an acceptance edge (or after reset); leaves valid
   // high so that back-to-back words need no second assignment in one step.
   task automatic send_word(input logic [tcwe_pkg::WORD_WIDTH-1:0] word,
                            input logic first, input logic last);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.plain_word <= word;
      req_bus.first_of_message <= first;
      req_bus.last_of_message <= last;
      do @(posedge clock); while (!req_bus.ready);
      queue_cipher(word, first, last);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_cipher.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tcwe_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [tcwe_pkg::WORD_WIDTH-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_key_write(index, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_key(input tcwe_pkg::key_type k);
      write_csr(tcwe_pkg::KEY_WORD0_INDEX, k.k0);
      write_csr(tcwe_pkg::KEY_WORD1_INDEX, k.k1);
      write_csr(tcwe_pkg::KEY_WORD2_INDEX, k.k2);
      write_csr(tcwe_pkg::KEY_WORD3_INDEX, k.k3);
      if ($urandom_range(0, 1) == 0) begin
         write_csr(tcwe_pkg::CSR_INDEX_WIDTH'($urandom_range(SPARE_INDEX, TOP_INDEX)),
                   $urandom);
      end
   endtask

   // Mostly well-formed messages of a few words, with some stray words
   // carrying arbitrary first/last marks mixed in.
   task automatic send_messages(input int word_total);
      int sent;
      int length;
      int w;
      sent = 0;
      while (sent < word_total) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            length = $urandom_range(1, 8);
            for (w = 0; w < length; w++) begin
               send_word($urandom, w == 0, w == length - 1);
            end
            sent += length;
         end
         if ($urandom_range(0, 29) == 0) begin
            drain_results();
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      cipher_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_cipher.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected word: got %h chain %b end %b", rsp_bus.cipher_word,
                        rsp_bus.is_chain_word, rsp_bus.end_of_run);
            end
         end else begin
            want = pending_cipher.pop_front();
            if (rsp_bus.cipher_word !== want.cipher_word ||
                rsp_bus.is_chain_word !== want.is_chain_word ||
                rsp_bus.end_of_run !== want.end_of_run) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("word mismatch: expected %h chain %b end %b, got %h chain %b end %b",
                           want.cipher_word, want.is_chain_word, want.end_of_run,
                           rsp_bus.cipher_word, rsp_bus.is_chain_word, rsp_bus.end_of_run);
               end
            end
         end
      end
   end

   // Result side: random stall bursts, ready stretches, and one long hold-off
   // on request so that the row of round cells fills and blocks the input.
   initial begin
      int held;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   initial begin
      tcwe_pkg::key_type k;
      int                row;
      int                phase;
      int                n;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.plain_word = '0;
      req_bus.first_of_message = 1'b0;
      req_bus.last_of_message = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      key_shadow = '0;
      chain_shadow = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < $size(directed_words); row++) begin
         send_word(directed_words[row].plain_word, directed_words[row].first_of_message,
                   directed_words[row].last_of_message);
      end

      // Writes past the key registers must leave the key untouched.
      drain_results();
      write_csr(SPARE_INDEX, 32'hFFFF_FFFF);
      write_csr(LAST_INDEX, 32'hFFFF_FFFF);
      send_word(32'hA5A5_A5A5, 1'b1, 1'b1);
      send_word(32'h5A5A_5A5A, 1'b0, 1'b1);

      for (phase = 0; phase < KEY_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: k = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            1: k = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
            default: k = '{$urandom, $urandom, $urandom, $urandom};
         endcase
         load_key(k);
         if (phase == KEY_PHASES - 1) begin
            quiet = 1'b1;
         end
         send_messages(WORDS_PER_PHASE);
         if (phase == 2) begin
            drain_results();
            hold_request = 1'b1;
            for (n = 0; n < BURST_WORDS; n++) begin
               send_word($urandom, 1'b1, 1'($urandom_range(0, 1)));
            end
         end
      end

      drain_results();
      repeat (tcwe_pkg::DEFAULT_ROUNDS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
